FILE: design/kor_pkg.sv
// shared constants, types and fixed-point helpers for the orbit integrator
package kor_pkg;

  // word format
  localparam int W      = 48;
  localparam int F      = 32;
  localparam int PW     = 2 * W;
  localparam int TW     = 47;
  localparam int HW     = 33;
  localparam int GW     = 47;
  localparam int CW     = 21;
  localparam int CFG_IW = 3;
  localparam int RW     = W + 4;
  localparam int DG     = 16;
  localparam int MSTEPS = W / DG;
  localparam int CNTW   = $clog2(W + 1);

  localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [TW-1:0]       TMAX = {TW{1'b1}};
  localparam logic [PW-F-1:0]     HI_LIM = (PW-F)'(1) << (W - 1);

  // divide by six for magnitudes up to 2^47: ((m >> 1) * DIV3_MUL) >> DIV3_SH
  localparam int           DIV3_SH  = W + 1;
  localparam logic [W-1:0] DIV3_MUL = W'((64'd1 << DIV3_SH) / 64'd3 + 64'd1);

  // register reset values
  localparam logic [W-1:0]  RST_PX    = W'(64'd499504697);
  localparam logic [W-1:0]  RST_PY    = W'(64'd4197042043);
  localparam logic [W-1:0]  RST_VX    = W'(-64'sd27273042330);
  localparam logic [W-1:0]  RST_VY    = W'(64'd2602750181);
  localparam logic [HW-1:0] RST_STEP  = HW'(64'd42949673);
  localparam logic [TW-1:0] RST_START = '0;
  localparam logic [GW-1:0] RST_GRAV  = GW'(64'd169363015887);
  localparam logic [CW-1:0] RST_COUNT = CW'(2001);

  // configuration register indexes
  typedef enum logic [CFG_IW-1:0] {
    REG_INIT_PX, REG_INIT_PY, REG_INIT_VX, REG_INIT_VY,
    REG_STEP, REG_START_TIME, REG_GRAV, REG_COUNT
  } kor_reg_t;

  // shared unit operations
  typedef enum logic [1:0] {OP_MUL, OP_SQRT, OP_DIV} kor_op_t;

  typedef struct packed {
    logic    start;
    kor_op_t op;
  } kor_req_t;

  typedef struct packed {
    logic done;
    logic sat;
  } kor_rsp_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE, ST_SQX, ST_SQY, ST_SQRT, ST_DIV, ST_AX, ST_AY, ST_SLOPE,
    ST_UPX, ST_UPY, ST_UVX, ST_UVY, ST_FDIV, ST_FMUL, ST_OUT
  } kor_state_t;

  // saturating add on the signed word
  function automatic logic signed [W-1:0] sadd(logic signed [W-1:0] a,
                                               logic signed [W-1:0] b);
    logic signed [W:0] s;
    s = {a[W-1], a} + {b[W-1], b};
    if (s[W] != s[W-1]) return s[W] ? WMIN : WMAX;
    return s[W-1:0];
  endfunction

  // negation with the most negative word mapped to the largest
  function automatic logic signed [W-1:0] sneg(logic signed [W-1:0] a);
    return (a == WMIN) ? WMAX : -a;
  endfunction

  // magnitude of a signed word
  function automatic logic [W-1:0] umag(logic signed [W-1:0] a);
    return a[W-1] ? W'(-a) : W'(a);
  endfunction

  // scale an exact magnitude product, apply sign and saturate
  function automatic logic signed [W-1:0] smul_fin(logic [PW-1:0] p, logic neg);
    logic [PW-F-1:0] hi;
    hi = p[PW-1:F];
    if (hi >= HI_LIM) return neg ? WMIN : WMAX;
    return neg ? -$signed(hi[W-1:0]) : $signed(hi[W-1:0]);
  endfunction

endpackage

FILE: design/kor_in_if.sv
// input channel: one restart flag per transaction
interface kor_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source(output valid, output restart, input ready);
  modport sink(input valid, input restart, output ready);
endinterface

FILE: design/kor_out_if.sv
// result channel: one orbit point per transaction
interface kor_out_if;
  import kor_pkg::*;
  logic                valid;
  logic                ready;
  logic [TW-1:0]       time_now;
  logic signed [W-1:0] pos_x;
  logic signed [W-1:0] pos_y;
  logic signed [W-1:0] vel_x;
  logic signed [W-1:0] vel_y;
  logic                last_point;
  logic                singular;

  modport source(output valid, output time_now, output pos_x, output pos_y,
                 output vel_x, output vel_y, output last_point, output singular,
                 input ready);
  modport sink(input valid, input time_now, input pos_x, input pos_y,
               input vel_x, input vel_y, input last_point, input singular,
               output ready);
endinterface

FILE: design/kor_unit.sv
// shared arithmetic unit: digit-serial multiply, bit-serial sqrt and divide
module kor_unit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  kor_pkg::kor_req_t     req,
  input  logic [kor_pkg::PW-1:0] opa,
  input  logic [kor_pkg::W-1:0]  opb,
  output kor_pkg::kor_rsp_t     rsp,
  output logic [kor_pkg::PW-1:0] res_r
);
  import kor_pkg::*;

  kor_op_t         op_r;
  logic            busy_r;
  logic            done_r;
  logic            sat_r;
  logic [CNTW-1:0] cnt_r;
  logic [PW-1:0]   a_r;
  logic [W-1:0]    b_r;
  logic [RW-1:0]   rem_r;

  logic [W+DG-1:0] mp;
  logic [RW-1:0]   sq_t;
  logic [RW-1:0]   sq_trial;
  logic [W:0]      dchk;
  logic [W:0]      dt;

  // one partial product, one sqrt trial, one divide trial
  always_comb begin
    mp       = a_r[W-1:0] * b_r[W-1:W-DG];
    sq_t     = {rem_r[RW-3:0], a_r[PW-1:PW-2]};
    sq_trial = RW'({res_r[W-1:0], 2'b01});
    dchk     = a_r[PW-1:PW-W-1];
    dt       = {rem_r[W-1:0], a_r[PW-1]};
  end

  assign rsp.done = done_r;
  assign rsp.sat  = sat_r;

  // operation sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        op_r   <= req.op;
        busy_r <= 1'b1;
        a_r    <= opa;
        b_r    <= opb;
        rem_r  <= '0;
        res_r  <= '0;
        sat_r  <= 1'b0;
        cnt_r  <= (req.op == OP_MUL) ? CNTW'(MSTEPS) : CNTW'(W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNTW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        unique case (op_r)
          OP_MUL: begin
            res_r <= (res_r << DG) + PW'(mp);
            b_r   <= b_r << DG;
          end
          OP_SQRT: begin
            a_r <= a_r << 2;
            if (sq_t >= sq_trial) begin
              rem_r <= sq_t - sq_trial;
              res_r <= {res_r[PW-2:0], 1'b1};
            end else begin
              rem_r <= sq_t;
              res_r <= {res_r[PW-2:0], 1'b0};
            end
          end
          OP_DIV: begin
            if (cnt_r == CNTW'(W)) begin
              // quotient too large for the word
              if (dchk >= {1'b0, b_r}) begin
                sat_r  <= 1'b1;
                busy_r <= 1'b0;
                done_r <= 1'b1;
              end
              rem_r <= RW'(dchk[W-1:0]);
              a_r   <= a_r << (W + 1);
            end else begin
              a_r <= a_r << 1;
              if (dt >= {1'b0, b_r}) begin
                rem_r <= RW'(dt - {1'b0, b_r});
                res_r <= {res_r[PW-2:0], 1'b1};
              end else begin
                rem_r <= RW'(dt);
                res_r <= {res_r[PW-2:0], 1'b0};
              end
            end
          end
          default: begin
            busy_r <= 1'b0;
            done_r <= 1'b1;
          end
        endcase
      end
    end
  end

endmodule

FILE: design/kepler_orbit_rk4_step_core.sv
// planar two-body RK4 orbit stepper on a shared multiply/sqrt/divide unit
//
//   port      dir  contents
//   in_ch     in   restart flag
//   out_ch    out  time, position, velocity, last point, singular flag
//   cfg_*     in   register write: enable, index, data
//
// A step runs four force evaluations, each a squared radius (2 multiplies),
// a square root, three divides and two multiplies, then the stage updates,
// four reciprocal multiplies for the divide by six and four multiplies.
// Reset is synchronous; a finished point waits in the output register while
// the next transaction runs, which stalls before output.
module kepler_orbit_rk4_step_core (
  input  logic                      clk,
  input  logic                      rst_n,
  kor_in_if.sink                    in_ch,
  kor_out_if.source                 out_ch,
  input  logic                      cfg_we,
  input  logic [kor_pkg::CFG_IW-1:0] cfg_index,
  input  logic [kor_pkg::W-1:0]     cfg_data
);
  import kor_pkg::*;

  // configuration registers
  logic signed [W-1:0] init_r [4];
  logic [HW-1:0]       step_r;
  logic [TW-1:0]       stime_r;
  logic [GW-1:0]       grav_r;
  logic [CW-1:0]       count_r;

  // integrator state and working registers
  kor_state_t          state_r, state_nxt;
  logic signed [W-1:0] base_r [4];
  logic signed [W-1:0] pq_r [4];
  logic signed [W-1:0] acc_r [2];
  logic signed [W-1:0] sv_r [4];
  logic signed [W-1:0] f_r;
  logic [W-1:0]        mag_r;
  logic [PW-1:0]       sq_r;
  logic [1:0]          stg_r;
  logic [1:0]          idx_r;
  logic                sing_r;
  logic                last_r;
  logic [TW-1:0]       ctime_r;
  logic [CW-1:0]       pdone_r;
  logic                wait_r;

  // output register
  logic                ov_r;
  logic [TW-1:0]       o_time_r;
  logic signed [W-1:0] o_pv_r [4];
  logic                o_last_r;
  logic                o_sing_r;

  // unit connection
  kor_req_t            req;
  kor_rsp_t            rsp;
  logic [PW-1:0]       ures;
  logic [PW-1:0]       opa;
  logic [W-1:0]        opb;
  logic                mneg;
  logic                op_state;

  logic [CW-1:0]       cnt_eff;
  logic [W-1:0]        h48;
  logic [W-1:0]        hc;
  logic signed [W-1:0] smr;
  logic signed [W-1:0] sv_sel;
  logic signed [W-1:0] slope_nxt [4];
  logic signed [W-1:0] slope_in [4];
  logic [W-1:0]        qdiv;
  logic [W-1:0]        q6;
  logic [TW:0]         tsum;
  logic                out_free;

  assign cnt_eff  = (count_r == '0) ? CW'(1) : count_r;
  assign h48      = W'(step_r);
  assign hc       = stg_r[1] ? h48 : (h48 >> 1);
  assign sv_sel   = sv_r[idx_r];
  assign smr      = smul_fin(ures, mneg);
  assign qdiv     = ures[W-1:0];
  assign q6       = W'(ures[PW-1:DIV3_SH]);
  assign tsum     = {1'b0, ctime_r} + (TW+1)'(step_r);
  assign out_free = !ov_r || out_ch.ready;

  assign in_ch.ready       = (state_r == ST_IDLE);
  assign out_ch.valid      = ov_r;
  assign out_ch.time_now   = o_time_r;
  assign out_ch.pos_x      = o_pv_r[0];
  assign out_ch.pos_y      = o_pv_r[1];
  assign out_ch.vel_x      = o_pv_r[2];
  assign out_ch.vel_y      = o_pv_r[3];
  assign out_ch.last_point = o_last_r;
  assign out_ch.singular   = o_sing_r;

  kor_unit u_unit (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .opa   (opa),
    .opb   (opb),
    .rsp   (rsp),
    .res_r (ures)
  );

  // weighted slope accumulation, weights 1 2 2 1
  always_comb begin
    slope_in[0] = pq_r[2];
    slope_in[1] = pq_r[3];
    slope_in[2] = acc_r[0];
    slope_in[3] = acc_r[1];
    for (int j = 0; j < 4; j++) begin
      if (stg_r == 2'd0) slope_nxt[j] = slope_in[j];
      else if (stg_r == 2'd3) slope_nxt[j] = sadd(sv_r[j], slope_in[j]);
      else slope_nxt[j] = sadd(sadd(sv_r[j], slope_in[j]), slope_in[j]);
    end
  end

  // operand selection for the shared unit
  always_comb begin
    opa      = '0;
    opb      = '0;
    mneg     = 1'b0;
    op_state = 1'b1;
    req.op   = OP_MUL;
    unique case (state_r)
      ST_SQX: begin
        opa = PW'(umag(pq_r[0]));
        opb = umag(pq_r[0]);
      end
      ST_SQY: begin
        opa = PW'(umag(pq_r[1]));
        opb = umag(pq_r[1]);
      end
      ST_SQRT: begin
        req.op = OP_SQRT;
        opa    = sq_r;
      end
      ST_DIV: begin
        req.op = OP_DIV;
        opa    = {{(PW-F-W){f_r[W-1]}}, f_r, {F{1'b0}}};
        opb    = mag_r;
      end
      ST_AX: begin
        opa  = PW'(W'(f_r));
        opb  = umag(pq_r[0]);
        mneg = pq_r[0][W-1];
      end
      ST_AY: begin
        opa  = PW'(W'(f_r));
        opb  = umag(pq_r[1]);
        mneg = pq_r[1][W-1];
      end
      ST_UPX: begin
        opa  = PW'(hc);
        opb  = umag(pq_r[2]);
        mneg = pq_r[2][W-1];
      end
      ST_UPY: begin
        opa  = PW'(hc);
        opb  = umag(pq_r[3]);
        mneg = pq_r[3][W-1];
      end
      ST_UVX: begin
        opa  = PW'(hc);
        opb  = umag(acc_r[0]);
        mneg = acc_r[0][W-1];
      end
      ST_UVY: begin
        opa  = PW'(hc);
        opb  = umag(acc_r[1]);
        mneg = acc_r[1][W-1];
      end
      ST_FDIV: begin
        // halved magnitude times the reciprocal of three
        opa = PW'(umag(sv_sel) >> 1);
        opb = DIV3_MUL;
      end
      ST_FMUL: begin
        opa  = PW'(h48);
        opb  = umag(sv_sel);
        mneg = sv_sel[W-1];
      end
      default: op_state = 1'b0;
    endcase
    req.start = op_state && !wait_r;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          if (in_ch.restart || pdone_r == '0 || pdone_r >= cnt_eff) state_nxt = ST_OUT;
          else state_nxt = ST_SQX;
        end
      end
      ST_SQX:  if (rsp.done) state_nxt = ST_SQY;
      ST_SQY:  if (rsp.done) state_nxt = ST_SQRT;
      ST_SQRT: if (rsp.done) state_nxt = (ures[W-1:0] == '0) ? ST_AX : ST_DIV;
      ST_DIV:  if (rsp.done && idx_r == 2'd2) state_nxt = ST_AX;
      ST_AX:   if (rsp.done) state_nxt = ST_AY;
      ST_AY:   if (rsp.done) state_nxt = ST_SLOPE;
      ST_SLOPE: state_nxt = (stg_r == 2'd3) ? ST_FDIV : ST_UPX;
      ST_UPX:  if (rsp.done) state_nxt = ST_UPY;
      ST_UPY:  if (rsp.done) state_nxt = ST_UVX;
      ST_UVX:  if (rsp.done) state_nxt = ST_UVY;
      ST_UVY:  if (rsp.done) state_nxt = ST_SQX;
      ST_FDIV: if (rsp.done && idx_r == 2'd3) state_nxt = ST_FMUL;
      ST_FMUL: if (rsp.done && idx_r == 2'd3) state_nxt = ST_OUT;
      ST_OUT:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_r[0] <= RST_PX;
      init_r[1] <= RST_PY;
      init_r[2] <= RST_VX;
      init_r[3] <= RST_VY;
      step_r    <= RST_STEP;
      stime_r   <= RST_START;
      grav_r    <= RST_GRAV;
      count_r   <= RST_COUNT;
    end else if (cfg_we) begin
      unique case (kor_reg_t'(cfg_index))
        REG_INIT_PX:    init_r[0] <= cfg_data;
        REG_INIT_PY:    init_r[1] <= cfg_data;
        REG_INIT_VX:    init_r[2] <= cfg_data;
        REG_INIT_VY:    init_r[3] <= cfg_data;
        REG_STEP:       step_r    <= cfg_data[HW-1:0];
        REG_START_TIME: stime_r   <= cfg_data[TW-1:0];
        REG_GRAV:       grav_r    <= cfg_data[GW-1:0];
        REG_COUNT:      count_r   <= cfg_data[CW-1:0];
        default: ;
      endcase
    end
  end

  // unit handshake tracking
  always_ff @(posedge clk) begin
    if (!rst_n) wait_r <= 1'b0;
    else if (rsp.done) wait_r <= 1'b0;
    else if (req.start) wait_r <= 1'b1;
  end

  // integrator datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < 4; j++) base_r[j] <= '0;
      ctime_r <= '0;
      pdone_r <= '0;
      sing_r  <= 1'b0;
      last_r  <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_ch.valid) begin
            sing_r <= 1'b0;
            stg_r  <= '0;
            if (in_ch.restart) begin
              for (int j = 0; j < 4; j++) base_r[j] <= init_r[j];
              ctime_r <= stime_r;
              pdone_r <= CW'(1);
              last_r  <= (cnt_eff == CW'(1));
            end else if (pdone_r == '0) begin
              last_r <= 1'b0;
            end else if (pdone_r >= cnt_eff) begin
              last_r <= 1'b1;
            end else begin
              for (int j = 0; j < 4; j++) pq_r[j] <= base_r[j];
            end
          end
        end
        ST_SQX: if (rsp.done) sq_r <= ures;
        ST_SQY: if (rsp.done) sq_r <= sq_r + ures;
        ST_SQRT: begin
          if (rsp.done) begin
            mag_r <= ures[W-1:0];
            idx_r <= '0;
            if (ures[W-1:0] == '0) begin
              // zero radius: saturated factor
              f_r    <= WMAX;
              sing_r <= 1'b1;
            end else begin
              f_r <= W'($signed(grav_r));
            end
          end
        end
        ST_DIV: begin
          if (rsp.done) begin
            f_r   <= rsp.sat ? WMAX : $signed(qdiv);
            idx_r <= idx_r + 1'b1;
          end
        end
        ST_AX: if (rsp.done) acc_r[0] <= sneg(smr);
        ST_AY: if (rsp.done) acc_r[1] <= sneg(smr);
        ST_SLOPE: begin
          for (int j = 0; j < 4; j++) sv_r[j] <= slope_nxt[j];
          idx_r <= '0;
        end
        ST_UPX: if (rsp.done) pq_r[0] <= sadd(base_r[0], smr);
        ST_UPY: if (rsp.done) pq_r[1] <= sadd(base_r[1], smr);
        ST_UVX: if (rsp.done) pq_r[2] <= sadd(base_r[2], smr);
        ST_UVY: begin
          if (rsp.done) begin
            pq_r[3] <= sadd(base_r[3], smr);
            stg_r   <= stg_r + 1'b1;
          end
        end
        ST_FDIV: begin
          if (rsp.done) begin
            sv_r[idx_r] <= sv_sel[W-1] ? -$signed(q6) : $signed(q6);
            idx_r       <= idx_r + 1'b1;
          end
        end
        ST_FMUL: begin
          if (rsp.done) begin
            base_r[idx_r] <= sadd(base_r[idx_r], smr);
            idx_r         <= idx_r + 1'b1;
            if (idx_r == 2'd3) begin
              ctime_r <= tsum[TW] ? TMAX : tsum[TW-1:0];
              pdone_r <= pdone_r + 1'b1;
              last_r  <= (CW'(pdone_r + 1'b1) >= cnt_eff);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      if (out_ch.ready) ov_r <= 1'b0;
      if (state_r == ST_OUT && out_free) begin
        ov_r     <= 1'b1;
        o_time_r <= ctime_r;
        for (int j = 0; j < 4; j++) o_pv_r[j] <= base_r[j];
        o_last_r <= last_r;
        o_sing_r <= sing_r;
      end
    end
  end

endmodule
